@@ src/asgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR colour filter package
// Parser modes, colour effect codes, byte constants, the parser state record
// and the SGR argument fold used by the step logic.
// ----------------------------------------------------------------------------
package asgr_pkg;

    // Parser modes; the two unused codes fall back to plain text.
    typedef enum logic [2:0] {
        MODE_PLAIN     = 3'd0,
        MODE_ESC       = 3'd1,
        MODE_CSI_ENTER = 3'd2,
        MODE_CSI_ARG   = 3'd3,
        MODE_OTHER     = 3'd5,
        MODE_SKIP      = 3'd6
    } asgr_mode_t;

    // Net effect of the SGR arguments on one colour flag.
    typedef enum logic [1:0] {
        EFF_KEEP  = 2'd0,
        EFF_CLEAR = 2'd1,
        EFF_SET   = 2'd2
    } asgr_eff_t;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 6;
    localparam int ARG_W  = 16;
    localparam int ADDR_W = 1;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_BG_MATCH = 1'd0;
    localparam logic [ADDR_W-1:0] REG_FG_MATCH = 1'd1;

    localparam logic [CODE_W-1:0] BG_MATCH_RESET = 6'd42;
    localparam logic [CODE_W-1:0] FG_MATCH_RESET = 6'd32;

    // Stream bytes that steer the parser.
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_QUEST   = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_M       = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_H       = 8'h48;
    localparam logic [BYTE_W-1:0] CH_L       = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_Y       = 8'h79;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    // SGR codes with a fixed meaning.
    localparam logic [ARG_W-1:0] SGR_RESET    = 16'd0;
    localparam logic [ARG_W-1:0] SGR_FG_LO    = 16'd30;
    localparam logic [ARG_W-1:0] SGR_FG_HI    = 16'd37;
    localparam logic [ARG_W-1:0] SGR_FG_EXT   = 16'd38;
    localparam logic [ARG_W-1:0] SGR_FG_DEF   = 16'd39;
    localparam logic [ARG_W-1:0] SGR_BG_LO    = 16'd40;
    localparam logic [ARG_W-1:0] SGR_BG_HI    = 16'd47;
    localparam logic [ARG_W-1:0] SGR_BG_EXT   = 16'd48;
    localparam logic [ARG_W-1:0] SGR_BG_DEF   = 16'd49;
    localparam logic [ARG_W-1:0] ARG_MAX      = 16'hFFFF;
    localparam logic [3:0]       DEC_RADIX    = 4'd10;

    // Complete parser state.
    typedef struct packed {
        asgr_mode_t       mode;
        logic             fg_flag;
        logic             bg_flag;
        logic [ARG_W-1:0] arg_value;
        asgr_eff_t        fg_eff;
        asgr_eff_t        bg_eff;
    } asgr_state_t;

    typedef struct packed {
        asgr_eff_t fg_eff;
        asgr_eff_t bg_eff;
    } asgr_eff_pair_t;

    // Fold one completed argument into the running effects; later tests win.
    function automatic asgr_eff_pair_t fold_arg(
        input logic [ARG_W-1:0]  num,
        input logic [CODE_W-1:0] fg_code,
        input logic [CODE_W-1:0] bg_code,
        input asgr_eff_pair_t    cur
    );
        asgr_eff_t      f;
        asgr_eff_t      b;
        asgr_eff_pair_t res;
        f = EFF_KEEP;
        b = EFF_KEEP;
        if (num >= SGR_BG_LO && num <= SGR_BG_HI) b = EFF_CLEAR;
        if (num == {{(ARG_W-CODE_W){1'b0}}, bg_code}) b = EFF_SET;
        if (num >= SGR_FG_LO && num <= SGR_FG_HI) f = EFF_CLEAR;
        if (num == {{(ARG_W-CODE_W){1'b0}}, fg_code}) f = EFF_SET;
        if (num == SGR_RESET)
        begin
            f = EFF_CLEAR;
            b = EFF_CLEAR;
        end
        if (num == SGR_FG_DEF) f = EFF_CLEAR;
        if (num == SGR_BG_DEF) b = EFF_CLEAR;
        if (num == SGR_FG_EXT) f = EFF_CLEAR;
        if (num == SGR_BG_EXT) b = EFF_CLEAR;
        res = cur;
        if (f != EFF_KEEP) res.fg_eff = f;
        if (b != EFF_KEEP) res.bg_eff = b;
        return res;
    endfunction

endpackage

@@ src/asgr_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR colour filter step logic
// Combinational next state for one byte: the byte may pass through up to
// two parser modes before it is consumed, and may be emitted as plain text.
// ----------------------------------------------------------------------------
module asgr_step
    import asgr_pkg::*;
(
    input  asgr_state_t       st,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [CODE_W-1:0] fg_code,
    input  logic [CODE_W-1:0] bg_code,
    output asgr_state_t       st_next,
    output logic              emit
);

    logic             is_digit;
    logic             do_other;
    logic             do_arg;
    logic             do_plain;
    logic [ARG_W-1:0] arg_in;
    asgr_eff_pair_t   eff_in;
    asgr_eff_pair_t   eff_fold;
    logic [19:0]      arg_acc;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

    // Entry from CSI entry starts the argument list with both effects at keep.
    assign eff_fold = fold_arg(arg_in, fg_code, bg_code, eff_in);
    assign arg_acc  = ({4'd0, arg_in} * {16'd0, DEC_RADIX}) + {16'd0, in_byte[3:0]};

    always_comb
    begin
        st_next  = st;
        emit     = 1'b0;
        do_other = 1'b0;
        do_arg   = 1'b0;
        do_plain = 1'b0;
        arg_in   = st.arg_value;
        eff_in   = '{fg_eff: st.fg_eff, bg_eff: st.bg_eff};

        // First mode the byte meets.
        unique case (st.mode)
            MODE_ESC:
            begin
                if (in_byte == CH_LBRACK || in_byte == CH_QUEST)
                    st_next.mode = MODE_CSI_ENTER;
                else
                    do_other = 1'b1;
            end
            MODE_OTHER:
            begin
                do_other = 1'b1;
            end
            MODE_SKIP:
            begin
                st_next.mode = MODE_PLAIN;
            end
            MODE_CSI_ENTER:
            begin
                if (is_digit || in_byte == CH_SEMI || in_byte == CH_M)
                begin
                    arg_in = '0;
                    eff_in = '{fg_eff: EFF_KEEP, bg_eff: EFF_KEEP};
                    do_arg = 1'b1;
                end
                else if (in_byte == CH_H)
                begin
                    st_next.mode = MODE_PLAIN;
                    if (st.fg_eff == EFF_SET) st_next.fg_flag = 1'b1;
                    else if (st.fg_eff == EFF_CLEAR) st_next.fg_flag = 1'b0;
                    if (st.bg_eff == EFF_SET) st_next.bg_flag = 1'b1;
                    else if (st.bg_eff == EFF_CLEAR) st_next.bg_flag = 1'b0;
                end
                else
                    do_plain = 1'b1;
            end
            MODE_CSI_ARG:
            begin
                do_arg = 1'b1;
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        // Escape that is not a CSI introducer.
        if (do_other)
        begin
            if (in_byte == ESC_BYTE)
                st_next.mode = MODE_ESC;
            else if (in_byte == CH_LPAREN || in_byte == CH_RPAREN)
                st_next.mode = MODE_SKIP;
            else
                st_next.mode = MODE_PLAIN;
        end

        // Argument collection.
        if (do_arg)
        begin
            st_next.mode      = MODE_CSI_ARG;
            st_next.arg_value = arg_in;
            st_next.fg_eff    = eff_in.fg_eff;
            st_next.bg_eff    = eff_in.bg_eff;
            if (in_byte == CH_LBRACK)
            begin
                st_next.fg_eff = EFF_KEEP;
                st_next.bg_eff = EFF_KEEP;
                st_next.mode   = MODE_CSI_ENTER;
            end
            else if (in_byte == CH_M)
            begin
                st_next.fg_eff = eff_fold.fg_eff;
                st_next.bg_eff = eff_fold.bg_eff;
                if (eff_fold.fg_eff == EFF_SET) st_next.fg_flag = 1'b1;
                else if (eff_fold.fg_eff == EFF_CLEAR) st_next.fg_flag = 1'b0;
                if (eff_fold.bg_eff == EFF_SET) st_next.bg_flag = 1'b1;
                else if (eff_fold.bg_eff == EFF_CLEAR) st_next.bg_flag = 1'b0;
                st_next.mode = MODE_PLAIN;
            end
            else if (in_byte == CH_L || in_byte == CH_Y)
            begin
                st_next.fg_eff = EFF_KEEP;
                st_next.bg_eff = EFF_KEEP;
                st_next.mode   = MODE_PLAIN;
            end
            else if (in_byte == CH_SEMI)
            begin
                st_next.fg_eff    = eff_fold.fg_eff;
                st_next.bg_eff    = eff_fold.bg_eff;
                st_next.arg_value = '0;
            end
            else if (is_digit)
            begin
                if (arg_acc > {4'd0, ARG_MAX})
                    st_next.arg_value = ARG_MAX;
                else
                    st_next.arg_value = arg_acc[ARG_W-1:0];
            end
            else
                st_next.mode = MODE_PLAIN;
        end

        // Plain text: pass the byte only while both colours match.
        if (do_plain)
        begin
            st_next.mode = MODE_PLAIN;
            if (in_byte == ESC_BYTE)
                st_next.mode = MODE_ESC;
            else if (st.fg_flag && st.bg_flag)
                emit = 1'b1;
        end
    end

endmodule

@@ src/ansi_sgr_color_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR colour filter
// Parses escape and CSI sequences in a terminal byte stream and passes plain
// text bytes only while foreground and background match the set colours.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tdata[7:0] in_byte
//  m_*       out        tdata[7:0] out_byte, zero or one beat per input beat
//  cfg_*     in         index 0 bg_match_code, 1 fg_match_code, data[5:0]
//
// One byte is accepted every cycle unless an emitting byte waits on a stalled
// output; a byte crosses an input register, the parser step logic and the
// output register. Bytes that emit nothing never wait for the output.
// Reset puts the parser in plain text with both colour flags clear and the
// match codes at 42 and 32. A stalled output holds one result while one more
// byte waits in the input register.
// ----------------------------------------------------------------------------
module ansi_sgr_color_filter_unit
    import asgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CODE_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [CODE_W-1:0] bg_code_reg;
    logic [CODE_W-1:0] fg_code_reg;
    asgr_state_t       st_reg;
    asgr_state_t       st_next;
    logic              emit;
    logic              advance;

    asgr_step u_step (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .fg_code (fg_code_reg),
        .bg_code (bg_code_reg),
        .st_next (st_next),
        .emit    (emit)
    );

    // The held byte moves on unless it emits into a full, stalled output.
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_code_reg <= BG_MATCH_RESET;
            fg_code_reg <= FG_MATCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BG_MATCH: bg_code_reg <= cfg_data;
                REG_FG_MATCH: fg_code_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode      <= MODE_PLAIN;
            st_reg.fg_flag   <= 1'b0;
            st_reg.bg_flag   <= 1'b0;
            st_reg.arg_value <= '0;
            st_reg.fg_eff    <= EFF_KEEP;
            st_reg.bg_eff    <= EFF_KEEP;
        end
        else if (advance)
            st_reg <= st_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_byte_reg <= in_byte_reg;
    end

`ifndef ASSERT_OFF
    // A held byte only waits behind a stalled, full output.
    a_wait_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> out_valid_reg && !m_tready)
        else $error("input byte held without an output stall");

    // Parser state moves only when a byte is consumed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("parser state changed without a byte");

    // An emitted byte appears on the output in the next cycle.
    a_emit_data: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> m_tvalid && (m_tdata == $past(in_byte_reg)))
        else $error("emitted byte missing from the output");
`endif

endmodule

@@ tb/sv/asgr_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR colour filter scoreboard
// Holds a bit-exact copy of the parser, the colour flags and the match codes.
// Each accepted input beat is run through that copy. Any byte that should
// pass the filter is queued, and every output beat is compared against the
// oldest queued byte.
// ----------------------------------------------------------------------------
package asgr_scoreboard_pkg;

    import asgr_pkg::*;

    class sgr_filter_scoreboard;

        // Shadow of the parser state and the configuration.
        asgr_mode_t        mode;
        bit                fg_on;
        bit                bg_on;
        bit [ARG_W-1:0]    arg_acc;
        asgr_eff_t         fg_pend;
        asgr_eff_t         bg_pend;
        bit [CODE_W-1:0]   fg_code;
        bit [CODE_W-1:0]   bg_code;

        // Bytes that should still leave the filter, oldest first.
        logic [BYTE_W-1:0] passed_q[$];

        int unsigned       n_in;
        int unsigned       n_out;
        int unsigned       n_err;

        function new();
            mode    = MODE_PLAIN;
            fg_on   = 1'b0;
            bg_on   = 1'b0;
            arg_acc = '0;
            fg_pend = EFF_KEEP;
            bg_pend = EFF_KEEP;
            fg_code = FG_MATCH_RESET;
            bg_code = BG_MATCH_RESET;
            n_in    = 0;
            n_out   = 0;
            n_err   = 0;
        endfunction

        function void set_code(logic [ADDR_W-1:0] idx, logic [CODE_W-1:0] value);
            if (idx == REG_BG_MATCH)
                bg_code = value;
            else
                fg_code = value;
        endfunction

        function int unsigned pending();
            return passed_q.size();
        endfunction

        // Merge one finished SGR argument into the pending effects.
        // The tests run in a fixed order, and a later test overrides an
        // earlier one.
        function void merge_sgr_code(bit [ARG_W-1:0] num);
            asgr_eff_t f;
            asgr_eff_t b;
            f = EFF_KEEP;
            b = EFF_KEEP;
            if (num >= SGR_BG_LO && num <= SGR_BG_HI) b = EFF_CLEAR;
            if (num == ARG_W'(bg_code)) b = EFF_SET;
            if (num >= SGR_FG_LO && num <= SGR_FG_HI) f = EFF_CLEAR;
            if (num == ARG_W'(fg_code)) f = EFF_SET;
            if (num == SGR_RESET)
            begin
                f = EFF_CLEAR;
                b = EFF_CLEAR;
            end
            if (num == SGR_FG_DEF) f = EFF_CLEAR;
            if (num == SGR_BG_DEF) b = EFF_CLEAR;
            if (num == SGR_FG_EXT) f = EFF_CLEAR;
            if (num == SGR_BG_EXT) b = EFF_CLEAR;
            if (f != EFF_KEEP) fg_pend = f;
            if (b != EFF_KEEP) bg_pend = b;
        endfunction

        function void commit_effects();
            if (fg_pend == EFF_SET)
                fg_on = 1'b1;
            else if (fg_pend == EFF_CLEAR)
                fg_on = 1'b0;
            if (bg_pend == EFF_SET)
                bg_on = 1'b1;
            else if (bg_pend == EFF_CLEAR)
                bg_on = 1'b0;
        endfunction

        // Run one accepted byte through the parser.
        // A single byte may pass through up to two modes before it is used up.
        function void note_input(logic [BYTE_W-1:0] b);
            bit          done;
            bit          is_digit;
            int unsigned acc;
            done     = 1'b0;
            is_digit = (b >= CH_ZERO && b <= CH_NINE);
            n_in++;
            for (int g = 0; g < 8 && !done; g++)
            begin
                case (mode)
                    MODE_ESC:
                    begin
                        if (b == CH_LBRACK || b == CH_QUEST)
                        begin
                            mode = MODE_CSI_ENTER;
                            done = 1'b1;
                        end
                        else
                            mode = MODE_OTHER;
                    end
                    MODE_OTHER:
                    begin
                        if (b == ESC_BYTE)
                            mode = MODE_ESC;
                        else if (b == CH_LPAREN || b == CH_RPAREN)
                            mode = MODE_SKIP;
                        else
                            mode = MODE_PLAIN;
                        done = 1'b1;
                    end
                    MODE_SKIP:
                    begin
                        mode = MODE_PLAIN;
                        done = 1'b1;
                    end
                    MODE_CSI_ENTER:
                    begin
                        if (is_digit || b == CH_SEMI || b == CH_M)
                        begin
                            fg_pend = EFF_KEEP;
                            bg_pend = EFF_KEEP;
                            arg_acc = '0;
                            mode    = MODE_CSI_ARG;
                        end
                        else if (b == CH_H)
                        begin
                            commit_effects();
                            mode = MODE_PLAIN;
                            done = 1'b1;
                        end
                        else
                            mode = MODE_PLAIN;
                    end
                    MODE_CSI_ARG:
                    begin
                        if (b == CH_LBRACK)
                        begin
                            fg_pend = EFF_KEEP;
                            bg_pend = EFF_KEEP;
                            mode    = MODE_CSI_ENTER;
                        end
                        else if (b == CH_M)
                        begin
                            merge_sgr_code(arg_acc);
                            commit_effects();
                            mode = MODE_PLAIN;
                        end
                        else if (b == CH_L || b == CH_Y)
                        begin
                            fg_pend = EFF_KEEP;
                            bg_pend = EFF_KEEP;
                            mode    = MODE_PLAIN;
                        end
                        else if (b == CH_SEMI)
                        begin
                            merge_sgr_code(arg_acc);
                            arg_acc = '0;
                        end
                        else if (is_digit)
                        begin
                            // Decimal accumulation saturates at the top of the range.
                            acc = 32'(arg_acc) * 32'(DEC_RADIX) + 32'(b - CH_ZERO);
                            arg_acc = (acc > 32'(ARG_MAX)) ? ARG_MAX : acc[ARG_W-1:0];
                        end
                        else
                            mode = MODE_PLAIN;
                        done = 1'b1;
                    end
                    default:
                    begin
                        mode = MODE_PLAIN;
                        if (b == ESC_BYTE)
                            mode = MODE_ESC;
                        else if (fg_on && bg_on)
                            passed_q.push_back(b);
                        done = 1'b1;
                    end
                endcase
            end
        endfunction

        // Compare one output beat with the oldest byte still expected.
        function void check_output(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            n_out++;
            if (passed_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 40)
                    $display("%0t: unexpected out_byte: expected none, actual 0x%02h",
                             $time, got);
            end
            else
            begin
                want = passed_q.pop_front();
                if (got !== want)
                begin
                    n_err++;
                    if (n_err <= 40)
                        $display("%0t: out_byte mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want, got);
                end
            end
        endfunction

    endclass

endpackage

@@ tb/sv/ansi_sgr_color_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR colour filter testbench
// Drives terminal byte streams into the filter and checks every byte that
// comes out against the scoreboard. A short directed stream comes first.
// Random phases follow, each with its own pair of match codes. They mix
// SGR sequences, cursor re-applies, dropped and aborted sequences, other
// escapes and plain text. The sender works in bursts and the receiver
// stalls in changing patterns.
// ----------------------------------------------------------------------------
module ansi_sgr_color_filter_unit_tb;

    import asgr_pkg::*;
    import asgr_scoreboard_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 225;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              cfg_we   = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CODE_W-1:0] cfg_data = '0;

    sgr_filter_scoreboard sb;

    logic [BYTE_W-1:0] stim_q[$];
    int                burst_left   = 0;
    int                settings_run = 1;
    int unsigned       cycle_count  = 0;
    int unsigned       rx_left      = 0;
    int unsigned       rx_style     = 0;

    ansi_sgr_color_filter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Stop the run if it exceeds the cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver changes its stall style at irregular intervals.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_left[2:0] != 3'd0);
        endcase
    end

    // Check every output beat.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata);
    end

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            stim_q.push_back(s[i]);
    endfunction

    // Build the text of one SGR argument. The text may be empty, padded with
    // a leading zero, or long enough to overflow the argument.
    function automatic string arg_text();
        string s;
        int    v;
        v = 0;
        case ($urandom_range(0, 11))
            0:       v = 0;
            1:       v = $urandom_range(30, 37);
            2:       v = $urandom_range(40, 47);
            3:       v = $urandom_range(38, 39);
            4:       v = $urandom_range(48, 49);
            5, 6:    v = int'(sb.fg_code);
            7, 8:    v = int'(sb.bg_code);
            9:       v = $urandom_range(0, 120);
            10:      v = $urandom_range(60000, 999999);
            default: return "";
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0)
            s = {"0", s};
        return s;
    endfunction

    // Build a CSI sequence with random arguments and a random final byte.
    function automatic void add_sgr();
        int                nargs;
        logic [BYTE_W-1:0] odd;
        stim_q.push_back(ESC_BYTE);
        stim_q.push_back(($urandom_range(0, 5) == 0) ? CH_QUEST : CH_LBRACK);
        nargs = $urandom_range(0, 4);
        for (int i = 0; i < nargs; i++)
        begin
            if (i != 0)
                stim_q.push_back(CH_SEMI);
            push_text(arg_text());
        end
        case ($urandom_range(0, 9))
            6:  stim_q.push_back(CH_L);
            7:  stim_q.push_back(CH_Y);
            8:
            begin
                // Restart the sequence before it ends.
                stim_q.push_back(CH_LBRACK);
                push_text(arg_text());
                stim_q.push_back(CH_M);
            end
            9:
            begin
                // Abort the sequence with a byte the parser does not expect.
                do
                    odd = BYTE_W'($urandom_range(0, 255));
                while ((odd >= CH_ZERO && odd <= CH_NINE) || odd == CH_SEMI ||
                       odd == CH_M || odd == CH_L || odd == CH_Y || odd == CH_LBRACK);
                stim_q.push_back(odd);
                if ($urandom_range(0, 1) == 0)
                begin
                    stim_q.push_back(ESC_BYTE);
                    push_text("[H");
                end
            end
            default: stim_q.push_back(CH_M);
        endcase
    endfunction

    // Append one random fragment of a terminal stream.
    function automatic void add_fragment();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
            add_sgr();
        else if (k < 55)
        begin
            // Plain text: mostly printable characters, some raw bytes.
            for (int i = $urandom_range(1, 8); i > 0; i--)
                stim_q.push_back(BYTE_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(0, 255)
                                         : $urandom_range(32, 126)));
        end
        else if (k < 63)
        begin
            stim_q.push_back(ESC_BYTE);
            push_text("[H");
        end
        else if (k < 75)
        begin
            // Other escapes: charset selection, a repeated ESC, or any byte.
            stim_q.push_back(ESC_BYTE);
            case ($urandom_range(0, 3))
                0:       stim_q.push_back(CH_LPAREN);
                1:       stim_q.push_back(CH_RPAREN);
                2:       add_sgr();
                default: ;
            endcase
            stim_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else if (k < 83)
        begin
            // CSI introducer followed by one random byte, which may end it at once.
            stim_q.push_back(ESC_BYTE);
            stim_q.push_back(CH_LBRACK);
            stim_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            // Select both matching colours so that text gets through.
            stim_q.push_back(ESC_BYTE);
            push_text($sformatf("[%0d;%0d", sb.fg_code, sb.bg_code));
            stim_q.push_back(CH_M);
        end
    endfunction

    // Send the queued bytes in bursts, with gaps of random length between
    // bursts.
    task automatic send_stream();
        int                gap;
        logic [BYTE_W-1:0] b;
        while (stim_q.size() != 0)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            b = stim_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do
                @(posedge clk);
            while (!s_tready);
            sb.note_input(b);
        end
    endtask

    // Stop sending, wait for every expected byte, then let the pipeline empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CODE_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_code(idx, value);
    endtask

    task automatic reconfigure(input logic [CODE_W-1:0] bg, input logic [CODE_W-1:0] fg);
        wait_drained();
        write_reg(REG_BG_MATCH, bg);
        write_reg(REG_FG_MATCH, fg);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream: set both colours, then pass the lowest and highest
        // byte values. Next, a charset escape swallows an ESC. A reset
        // sequence then clears both colours. Last, an aborted sequence keeps
        // its arguments, and a cursor re-apply commits them.
        stim_q.push_back(ESC_BYTE);
        push_text("[32;42m");
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        stim_q.push_back(ESC_BYTE);
        stim_q.push_back(CH_LPAREN);
        stim_q.push_back(ESC_BYTE);
        push_text("B");
        stim_q.push_back(ESC_BYTE);
        push_text("?0mA");
        stim_q.push_back(ESC_BYTE);
        push_text("[32;42;X");
        stim_q.push_back(ESC_BYTE);
        push_text("[HC");
        send_stream();

        // Random phases, each with its own pair of match codes. They include
        // the range limits and a pair of codes outside the usual ranges.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       ;
                1:       reconfigure(6'd40, 6'd30);
                2:       reconfigure(6'd47, 6'd37);
                3:       reconfigure(6'd63, 6'd1);
                default: reconfigure(CODE_W'($urandom_range(40, 47)),
                                     CODE_W'($urandom_range(30, 37)));
            endcase
            while (stim_q.size() < PHASE_BYTES)
                add_fragment();
            send_stream();
        end

        wait_drained();
        $display("Sent %0d stream bytes across %0d colour settings.", sb.n_in, settings_run);
        $display("Checked %0d filtered bytes; %0d mismatches.", sb.n_out, sb.n_err);
        if (sb.n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
